@@ src/zre_pkg.sv @@
// Package of shared constants, register indexes and the remap function of the zero-run expander.
`default_nettype none
package zre_pkg;

    localparam int PIXELS_PER_RESULT = 4;
    localparam int REMAP_ENTRIES     = 16;
    localparam int LANE_COUNT        = (PIXELS_PER_RESULT < 1) ? 1 :
                                       (PIXELS_PER_RESULT > 4) ? 4 : PIXELS_PER_RESULT;

    localparam int CODE_W   = 8;
    localparam int PIXEL_W  = 8;
    localparam int COUNT_W  = 3;
    localparam int LEFT_W   = 9;
    localparam int IMAGE_W  = 16;
    localparam int TABLE_W  = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [LEFT_W-1:0] LANES_LEFT = LEFT_W'(LANE_COUNT);

    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_LOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP_HIGH   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_PIXELS = CFG_IDX_W'(3);

    function automatic logic [PIXEL_W-1:0] remap_pixel(
        input logic               enable,
        input logic [TABLE_W-1:0] low_entries,
        input logic [TABLE_W-1:0] high_entries,
        input logic [PIXEL_W-1:0] value
    );
        logic [PIXEL_W-1:0] result;
        result = value;
        if (enable && (value < PIXEL_W'(REMAP_ENTRIES)))
        begin
            if (value[3])
            begin
                result = high_entries[8*value[2:0] +: 8];
            end
            else
            begin
                result = low_entries[8*value[2:0] +: 8];
            end
        end
        return result;
    endfunction

endpackage
`default_nettype wire

@@ src/zre_cfg_if.sv @@
// Configuration write channel of the zero-run expander.
`default_nettype none
interface zre_cfg_if
    import zre_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TABLE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/zre_in_if.sv @@
// Coded byte input channel of the zero-run expander.
`default_nettype none
interface zre_in_if
    import zre_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code_byte;
    logic              final_byte;

    modport source (output valid, output code_byte, output final_byte, input ready);
    modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface
`default_nettype wire

@@ src/zre_out_if.sv @@
// Packed pixel result channel of the zero-run expander.
`default_nettype none
interface zre_out_if
    import zre_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_a;
    logic [PIXEL_W-1:0] pixel_b;
    logic [PIXEL_W-1:0] pixel_c;
    logic [PIXEL_W-1:0] pixel_d;
    logic [COUNT_W-1:0] pixel_count;
    logic               run_last;
    logic               image_done;
    logic               overflow;

    modport source (
        output valid, output pixel_a, output pixel_b, output pixel_c, output pixel_d,
        output pixel_count, output run_last, output image_done, output overflow,
        input ready
    );
    modport sink (
        input valid, input pixel_a, input pixel_b, input pixel_c, input pixel_d,
        input pixel_count, input run_last, input image_done, input overflow,
        output ready
    );
endinterface
`default_nettype wire

@@ src/zero_run_expander_with_remap.sv @@
// Top level of the zero-run expander: decoding, pixel clamping, remap and result packing.
//
//   Channel   Direction  Transaction
//   cfg       in         register index and write data
//   code_in   in         one coded byte and its final-buffer mark
//   pixel_out out        up to four packed pixels with count and status flags
//
// A byte that causes at most one result is taken when the result register is free or
// being emptied. A zero run of k kept pixels gives ceil(k/4) results, at least one,
// issued by the single shared packing counter; input is held off meanwhile. A full
// result register stalls the packing counter and thus the input. Reset clears the
// configuration registers, the decoding state, the pixel counter and the result valid
// flag; no clearing pass.
`default_nettype none
module zero_run_expander_with_remap
    import zre_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    zre_cfg_if.sink    cfg,
    zre_in_if.sink     code_in,
    zre_out_if.source  pixel_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                 state_reg, state_next;
    logic                 remap_enable_reg;
    logic [TABLE_W-1:0]   remap_low_reg;
    logic [TABLE_W-1:0]   remap_high_reg;
    logic [IMAGE_W-1:0]   image_pixels_reg;
    logic                 awaiting_reg, awaiting_next;
    logic [IMAGE_W-1:0]   written_reg, written_next;
    logic                 finished_reg, finished_next;

    logic [LEFT_W-1:0]    left_reg, left_next;
    logic [PIXEL_W-1:0]   px_reg, px_next;
    logic                 done_reg, done_next;
    logic                 ovf_reg, ovf_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]   out_px_reg [4];
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;
    logic                 out_ovf_reg;

    logic                 slot_free;
    logic                 accept;
    logic                 emit;
    logic [LEFT_W-1:0]    wanted;
    logic [PIXEL_W-1:0]   raw_px;
    logic                 item_done;
    logic [IMAGE_W-1:0]   room;
    logic [LEFT_W-1:0]    kept;
    logic                 load;
    logic [LEFT_W-1:0]    src_left;
    logic [LEFT_W-1:0]    lane_n;
    logic                 src_last;

    assign cfg.ready     = 1'b1;
    assign slot_free     = !out_valid_reg || pixel_out.ready;
    assign code_in.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = code_in.valid && code_in.ready;

    always_comb
    begin
        emit          = 1'b0;
        wanted        = '0;
        raw_px        = '0;
        item_done     = 1'b0;
        awaiting_next = awaiting_reg;
        if (!finished_reg)
        begin
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                emit          = 1'b1;
                item_done     = (code_in.code_byte == '0) || code_in.final_byte;
                wanted        = LEFT_W'(code_in.code_byte);
            end
            else if (code_in.code_byte == '0)
            begin
                if (code_in.final_byte)
                begin
                    emit      = 1'b1;
                    item_done = 1'b1;
                end
                else
                begin
                    awaiting_next = 1'b1;
                end
            end
            else
            begin
                emit      = 1'b1;
                wanted    = LEFT_W'(1);
                raw_px    = code_in.code_byte;
                item_done = code_in.final_byte;
            end
        end
    end

    assign room = (written_reg < image_pixels_reg) ? (image_pixels_reg - written_reg) : '0;
    assign kept = (IMAGE_W'(wanted) < room) ? wanted : LEFT_W'(room);

    assign src_left = (state_reg == ST_IDLE) ? kept : left_reg;
    assign src_last = (src_left <= LANES_LEFT);
    assign lane_n   = src_last ? src_left : LANES_LEFT;

    always_comb
    begin
        state_next    = state_reg;
        written_next  = written_reg;
        finished_next = finished_reg;
        left_next     = left_reg;
        px_next       = px_reg;
        done_next     = done_reg;
        ovf_next      = ovf_reg;
        load          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && emit)
                begin
                    load          = 1'b1;
                    written_next  = IMAGE_W'(written_reg + IMAGE_W'(kept));
                    finished_next = finished_reg || item_done;
                    px_next       = remap_pixel(remap_enable_reg, remap_low_reg,
                                                remap_high_reg, raw_px);
                    done_next     = item_done;
                    ovf_next      = (kept < wanted);
                    left_next     = src_left - lane_n;
                    if (!src_last)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    left_next = src_left - lane_n;
                    if (src_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            remap_enable_reg <= 1'b0;
            remap_low_reg    <= '0;
            remap_high_reg   <= '0;
            image_pixels_reg <= '0;
            awaiting_reg     <= 1'b0;
            written_reg      <= '0;
            finished_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            written_reg   <= written_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                awaiting_reg <= awaiting_next;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_REMAP_ENABLE: remap_enable_reg <= cfg.data[0];
                    CFG_REMAP_LOW:    remap_low_reg    <= cfg.data;
                    CFG_REMAP_HIGH:   remap_high_reg   <= cfg.data;
                    CFG_IMAGE_PIXELS: image_pixels_reg <= cfg.data[IMAGE_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        px_reg   <= px_next;
        done_reg <= done_next;
        ovf_reg  <= ovf_next;
        if (load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                out_px_reg[j] <= (LEFT_W'(j) < lane_n) ? px_next : '0;
            end
            out_count_reg <= COUNT_W'(lane_n);
            out_last_reg  <= src_last;
            out_done_reg  <= done_next;
            out_ovf_reg   <= ovf_next;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.pixel_a     = out_px_reg[0];
    assign pixel_out.pixel_b     = out_px_reg[1];
    assign pixel_out.pixel_c     = out_px_reg[2];
    assign pixel_out.pixel_d     = out_px_reg[3];
    assign pixel_out.pixel_count = out_count_reg;
    assign pixel_out.run_last    = out_last_reg;
    assign pixel_out.image_done  = out_done_reg;
    assign pixel_out.overflow    = out_ovf_reg;

endmodule
`default_nettype wire
